// ===== sv/mrq_pkg.sv =====
// Shared types and codes for the multicast reference-counted queue.
package mrq_pkg;

   localparam int SEQ_W    = 16;
   localparam int SEEN_W   = 4;
   localparam int HANDLE_W = 32;
   localparam int KIND_W   = 3;
   localparam int CID_W    = 3;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNSEEN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ELEM = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd4;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [SEEN_W-1:0]   seen;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== sv/mrq_channels.sv =====
// Handshake channel interfaces: request, response and control register write.
interface mrq_req_if import mrq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CID_W-1:0]    consumer_id;
   logic [SEQ_W-1:0]    seq_in;
   logic [HANDLE_W-1:0] data_handle;
   modport source (output valid, kind, consumer_id, seq_in, data_handle, input ready);
   modport sink (input valid, kind, consumer_id, seq_in, data_handle, output ready);
endinterface

interface mrq_rsp_if import mrq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CID_W-1:0]    slot_out;
   logic [SEQ_W-1:0]    seq_out;
   logic [HANDLE_W-1:0] handle_out;
   logic [SEQ_W-1:0]    unseen_count;
   modport source (output valid, status, slot_out, seq_out, handle_out, unseen_count,
                   input ready);
   modport sink (input valid, status, slot_out, seq_out, handle_out, unseen_count,
                 output ready);
endinterface

interface mrq_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== sv/mrq_ring.sv =====
// Entry ring memory: one registered read port, one write port with a seen-only write.
module mrq_ring import mrq_pkg::*; #(
   parameter int RING_DEPTH = 64,
   parameter int IW = 6
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_all,
   input  logic          wr_seen,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data
);

   logic [SEQ_W-1:0]    seq_mem [RING_DEPTH];
   logic [SEEN_W-1:0]   seen_mem [RING_DEPTH];
   logic [HANDLE_W-1:0] hdl_mem [RING_DEPTH];
   entry_type           rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_all) begin
         seq_mem[wr_addr] <= wr_data.seq;
         hdl_mem[wr_addr] <= wr_data.handle;
      end
      if (wr_all || wr_seen) begin
         seen_mem[wr_addr] <= wr_data.seen;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.seq    <= seq_mem[rd_addr];
         rd_data_ff.seen   <= seen_mem[rd_addr];
         rd_data_ff.handle <= hdl_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multicast_refcount_queue_core.sv =====
// Multicast reference-counted queue core: command sequencer around the entry ring memory.
// Write, unseen, reset, add and refused transactions go from S_DECODE straight to S_DONE;
//   get and move first confirm the consumer position, scanning entries when a consumer resumes.
// Remove: up to RING_DEPTH+2 moves, then a seen count sweep over every live entry.
// One transaction in flight; the single read port of the ring memory paces every step.
// Synchronous reset clears control and consumer state; the ring memory is not cleared.
module multicast_refcount_queue_core import mrq_pkg::*; #(
   parameter int RING_DEPTH    = 64,
   parameter int MAX_CONSUMERS = 8
) (
   input  logic  clock,
   input  logic  reset,
   mrq_req_if.sink   req,
   mrq_rsp_if.source rsp,
   mrq_csr_if.sink   csr
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int NW = $clog2(RING_DEPTH + 3);
   localparam int SW = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_DECODE   = 14'b00000000000010,
      S_CONF_RD  = 14'b00000000000100,
      S_CONF_CHK = 14'b00000000001000,
      S_MV_UPD   = 14'b00000000010000,
      S_LAST     = 14'b00000000100000,
      S_SRCH_RD  = 14'b00000001000000,
      S_SRCH_CHK = 14'b00000010000000,
      S_GET_RD   = 14'b00000100000000,
      S_GET_OUT  = 14'b00001000000000,
      S_SW_RD    = 14'b00010000000000,
      S_SW_WR    = 14'b00100000000000,
      S_FIN      = 14'b01000000000000,
      S_DONE     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [CID_W-1:0]    cid_ff, cid_in;
   logic [SEQ_W-1:0]    seqin_ff, seqin_in;
   logic [HANDLE_W-1:0] hdl_ff, hdl_in;

   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SEQ_W-1:0]  pgen_ff, pgen_in;
   logic [SEQ_W-1:0]  next_ff, next_in;
   logic [SEEN_W-1:0] total_ff, total_in;
   logic              stop_ff, stop_in;

   logic [MAX_CONSUMERS-1:0] act_ff, act_in;
   logic [MAX_CONSUMERS-1:0] cv_ff, cv_in;
   logic [SEQ_W-1:0] cgen_ff [MAX_CONSUMERS];
   logic [SEQ_W-1:0] cgen_in [MAX_CONSUMERS];
   logic [IW-1:0]    ci_ff [MAX_CONSUMERS];
   logic [IW-1:0]    ci_in [MAX_CONSUMERS];
   logic [SEQ_W-1:0] last_ff [MAX_CONSUMERS];
   logic [SEQ_W-1:0] last_in [MAX_CONSUMERS];

   logic [NW-1:0] rmn_ff, rmn_in;
   logic [CW-1:0] woff_ff, woff_in;
   logic [IW-1:0] waddr_ff, waddr_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CID_W-1:0]    res_slot_ff, res_slot_in;
   logic [SEQ_W-1:0]    res_seq_ff, res_seq_in;
   logic [HANDLE_W-1:0] res_hdl_ff, res_hdl_in;
   logic [SEQ_W-1:0]    res_unseen_ff, res_unseen_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CID_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [SEQ_W-1:0]    rsp_seq_ff, rsp_seq_in;
   logic [HANDLE_W-1:0] rsp_hdl_ff, rsp_hdl_in;
   logic [SEQ_W-1:0]    rsp_unseen_ff, rsp_unseen_in;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_all;
   logic          wr_seen;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   mrq_ring #(.RING_DEPTH(RING_DEPTH), .IW(IW)) u_ring (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_all  (wr_all),
      .wr_seen (wr_seen),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   function automatic logic [CW-1:0] ring_off(input logic [IW-1:0] pos,
                                              input logic [IW-1:0] hd);
      logic [CW-1:0] r;
      if (pos >= hd) begin
         r = CW'(pos) - CW'(hd);
      end else begin
         r = CW'(pos) + DEPTH_C - CW'(hd);
      end
      return r;
   endfunction

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] pos);
      return (pos == LAST_IDX) ? '0 : pos + 1'b1;
   endfunction

   logic          req_fire;
   logic [SW-1:0] cidx;
   logic          cid_ok;
   logic          slot_ok;
   logic          c_cv;
   logic [SEQ_W-1:0] c_gen;
   logic [IW-1:0]    c_ci;
   logic [SEQ_W-1:0] c_last;
   logic [CW:0]   tail_sum;
   logic [IW-1:0] tail_idx;
   logic          rsp_free;

   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign cidx    = SW'(cid_ff);
   assign cid_ok  = (32'(cid_ff) < MAX_CONSUMERS);
   assign slot_ok = cid_ok && act_ff[cidx];
   assign c_cv    = cv_ff[cidx];
   assign c_gen   = cgen_ff[cidx];
   assign c_ci    = ci_ff[cidx];
   assign c_last  = last_ff[cidx];
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail_idx = (tail_sum >= (CW+1)'(RING_DEPTH)) ?
                     IW'(tail_sum - (CW+1)'(RING_DEPTH)) : IW'(tail_sum);
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      logic          mv_fin;
      logic          mv_ok;
      logic          stale;
      logic          found;
      logic [SW-1:0] fidx;
      logic [SEEN_W-1:0] seen_new;
      logic [SEQ_W-1:0]  s_val;
      logic          has_next;

      state_in = state_ff;
      kind_in  = kind_ff;
      cid_in   = cid_ff;
      seqin_in = seqin_ff;
      hdl_in   = hdl_ff;
      head_in  = head_ff;
      count_in = count_ff;
      pgen_in  = pgen_ff;
      next_in  = next_ff;
      total_in = total_ff;
      stop_in  = stop_ff;
      act_in   = act_ff;
      cv_in    = cv_ff;
      cgen_in  = cgen_ff;
      ci_in    = ci_ff;
      last_in  = last_ff;
      rmn_in   = rmn_ff;
      woff_in  = woff_ff;
      waddr_in = waddr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_seq_in    = res_seq_ff;
      res_hdl_in    = res_hdl_ff;
      res_unseen_in = res_unseen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      rsp_unseen_in = rsp_unseen_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      wr_all   = 1'b0;
      wr_seen  = 1'b0;
      wr_addr  = tail_idx;
      wr_data  = '0;
      mv_fin   = 1'b0;
      mv_ok    = 1'b0;
      stale    = 1'b0;
      found    = 1'b0;
      fidx     = '0;
      seen_new = '0;
      s_val    = '0;
      has_next = 1'b0;

      if (csr.valid) begin
         stop_in = csr.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req.kind;
               cid_in   = req.consumer_id;
               seqin_in = req.seq_in;
               hdl_in   = req.data_handle;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in = ST_OK;
            res_slot_in   = cid_ff;
            res_seq_in    = '0;
            res_hdl_in    = '0;
            res_unseen_in = '0;
            state_in      = S_DONE;
            priority if (kind_ff == KIND_WRITE) begin
               if (count_ff >= DEPTH_C) begin
                  res_status_in = ST_FULL;
               end else begin
                  s_val = (seqin_ff != '0) ? seqin_ff : next_ff;
                  wr_all = 1'b1;
                  wr_data.seq = s_val;
                  wr_data.seen = '0;
                  wr_data.handle = hdl_ff;
                  count_in = count_ff + 1'b1;
                  next_in = s_val + 1'b1;
                  res_seq_in = s_val;
               end
            end else if (stop_ff && (kind_ff == KIND_GET || kind_ff == KIND_MOVE ||
                         kind_ff == KIND_UNSEEN || kind_ff == KIND_RESET ||
                         kind_ff == KIND_ADD)) begin
               res_status_in = ST_STOPPED;
            end else if (kind_ff == KIND_GET || kind_ff == KIND_MOVE) begin
               if (!slot_ok) begin
                  res_status_in = ST_NO_ELEM;
               end else begin
                  state_in = S_CONF_RD;
               end
            end else if (kind_ff == KIND_UNSEEN) begin
               if (!slot_ok) begin
                  res_status_in = ST_NO_ELEM;
               end else if (c_gen != pgen_ff) begin
                  res_unseen_in = next_ff;
               end else if (count_ff != '0) begin
                  res_unseen_in = next_ff - c_last;
               end
            end else if (kind_ff == KIND_RESET) begin
               head_in  = '0;
               count_in = '0;
               pgen_in  = pgen_ff + 1'b1;
               next_in  = 16'd1;
            end else if (kind_ff == KIND_ADD) begin
               for (int i = 0; i < MAX_CONSUMERS; i++) begin
                  if (!found && !act_ff[i]) begin
                     found = 1'b1;
                     fidx  = SW'(i);
                  end
               end
               if (found) begin
                  act_in[fidx]  = 1'b1;
                  cv_in[fidx]   = 1'b0;
                  cgen_in[fidx] = '0;
                  ci_in[fidx]   = '0;
                  last_in[fidx] = '0;
                  total_in      = total_ff + 1'b1;
                  res_slot_in   = CID_W'(fidx);
               end else begin
                  res_status_in = ST_NO_SLOT;
                  res_slot_in   = '0;
               end
            end else if (kind_ff == KIND_REMOVE) begin
               if (!slot_ok) begin
                  res_status_in = ST_NO_ELEM;
               end else begin
                  rmn_in   = '0;
                  state_in = S_CONF_RD;
               end
            end else begin
               res_status_in = ST_OK;
            end
         end
         S_CONF_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = S_CONF_CHK;
         end
         S_CONF_CHK: begin
            stale = c_cv && ((c_gen != pgen_ff) || (ring_off(c_ci, head_ff) >= count_ff) ||
                    ((count_ff != '0) && (c_last < rd_data.seq)));
            if (c_cv && !stale) begin
               rd_en   = 1'b1;
               rd_addr = c_ci;
               state_in = (kind_ff == KIND_GET) ? S_GET_OUT : S_MV_UPD;
            end else begin
               cv_in[cidx] = 1'b0;
               if (c_gen != pgen_ff) begin
                  mv_fin = 1'b1;
                  if (count_ff != '0) begin
                     mv_ok = 1'b1;
                     cv_in[cidx]   = 1'b1;
                     ci_in[cidx]   = head_ff;
                     last_in[cidx] = rd_data.seq;
                     cgen_in[cidx] = pgen_ff;
                  end
               end else begin
                  woff_in  = '0;
                  waddr_in = head_ff;
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_MV_UPD: begin
            seen_new = rd_data.seen + 1'b1;
            wr_seen  = 1'b1;
            wr_addr  = c_ci;
            wr_data.seen = seen_new;
            has_next = ((CW+1)'(ring_off(c_ci, head_ff)) + (CW+1)'(1)) < (CW+1)'(count_ff);
            if ((seen_new >= total_ff) && (c_ci == head_ff)) begin
               head_in  = inc_idx(head_ff);
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  pgen_in = pgen_ff + 1'b1;
                  next_in = 16'd1;
               end
            end
            if (has_next) begin
               ci_in[cidx] = inc_idx(c_ci);
               rd_en    = 1'b1;
               rd_addr  = inc_idx(c_ci);
               state_in = S_LAST;
            end else begin
               cv_in[cidx] = 1'b0;
               mv_fin = 1'b1;
            end
         end
         S_LAST: begin
            last_in[cidx] = rd_data.seq;
            cgen_in[cidx] = pgen_ff;
            mv_fin = 1'b1;
            mv_ok  = 1'b1;
         end
         S_SRCH_RD: begin
            if (woff_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = waddr_ff;
               state_in = S_SRCH_CHK;
            end else begin
               mv_fin = 1'b1;
            end
         end
         S_SRCH_CHK: begin
            if (rd_data.seq > c_last) begin
               cv_in[cidx]   = 1'b1;
               ci_in[cidx]   = waddr_ff;
               last_in[cidx] = rd_data.seq;
               cgen_in[cidx] = pgen_ff;
               mv_fin = 1'b1;
               mv_ok  = 1'b1;
            end else begin
               woff_in  = woff_ff + 1'b1;
               waddr_in = inc_idx(waddr_ff);
               state_in = S_SRCH_RD;
            end
         end
         S_GET_RD: begin
            rd_en    = 1'b1;
            rd_addr  = c_ci;
            state_in = S_GET_OUT;
         end
         S_GET_OUT: begin
            res_seq_in = rd_data.seq;
            res_hdl_in = (kind_ff == KIND_GET) ? rd_data.handle : '0;
            state_in   = S_DONE;
         end
         S_SW_RD: begin
            if (woff_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = waddr_ff;
               state_in = S_SW_WR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SW_WR: begin
            wr_seen  = 1'b1;
            wr_addr  = waddr_ff;
            wr_data.seen = rd_data.seen - 1'b1;
            woff_in  = woff_ff + 1'b1;
            waddr_in = inc_idx(waddr_ff);
            state_in = S_SW_RD;
         end
         S_FIN: begin
            total_in     = total_ff - 1'b1;
            act_in[cidx] = 1'b0;
            cv_in[cidx]  = 1'b0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_seq_in    = res_seq_ff;
               rsp_hdl_in    = res_hdl_ff;
               rsp_unseen_in = res_unseen_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mv_fin) begin
         if (kind_ff == KIND_REMOVE) begin
            if (mv_ok && ((rmn_ff + 1'b1) < NW'(RING_DEPTH + 2))) begin
               rmn_in   = rmn_ff + 1'b1;
               state_in = S_CONF_RD;
            end else begin
               woff_in  = '0;
               waddr_in = head_in;
               state_in = S_SW_RD;
            end
         end else if (mv_ok) begin
            state_in = S_GET_RD;
         end else begin
            res_status_in = ST_NO_ELEM;
            state_in      = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pgen_ff      <= 16'd1;
         next_ff      <= 16'd1;
         total_ff     <= '0;
         stop_ff      <= 1'b0;
         act_ff       <= '0;
         cv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CONSUMERS; i++) begin
            cgen_ff[i] <= '0;
            ci_ff[i]   <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pgen_ff      <= pgen_in;
         next_ff      <= next_in;
         total_ff     <= total_in;
         stop_ff      <= stop_in;
         act_ff       <= act_in;
         cv_ff        <= cv_in;
         rsp_valid_ff <= rsp_valid_in;
         cgen_ff      <= cgen_in;
         ci_ff        <= ci_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cid_ff        <= cid_in;
      seqin_ff      <= seqin_in;
      hdl_ff        <= hdl_in;
      rmn_ff        <= rmn_in;
      woff_ff       <= woff_in;
      waddr_ff      <= waddr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_seq_ff    <= res_seq_in;
      res_hdl_ff    <= res_hdl_in;
      res_unseen_ff <= res_unseen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_hdl_ff    <= rsp_hdl_in;
      rsp_unseen_ff <= rsp_unseen_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.slot_out     = rsp_slot_ff;
   assign rsp.seq_out      = rsp_seq_ff;
   assign rsp.handle_out   = rsp_hdl_ff;
   assign rsp.unseen_count = rsp_unseen_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above ring depth");

   a_total_match: assert property (@(posedge clock) disable iff (reset)
      total_ff == SEEN_W'($countones(act_ff)))
      else $error("consumer total out of step with active slots");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == S_DECODE)
      else $error("accepted transaction not decoded");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

endmodule
